// ----- hw/rtl/fsp_pkg.sv -----
// Shared types, codes and helpers of the FASTA stream parser.
`default_nettype none
package fsp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int LEN_FIELD_BITS = 32;

	// Input command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Result kinds
	localparam logic [2:0] KIND_HEADER_BYTE = 3'd0;
	localparam logic [2:0] KIND_HEADER_END  = 3'd1;
	localparam logic [2:0] KIND_SEQ_BYTE    = 3'd2;
	localparam logic [2:0] KIND_RECORD_END  = 3'd3;
	localparam logic [2:0] KIND_ERROR       = 3'd4;

	// Parser modes
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_HEADER   = 2'd1;
	localparam logic [1:0] MODE_SEQUENCE = 2'd2;
	localparam logic [1:0] MODE_ERROR    = 2'd3;

	// Characters
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0A;

	typedef logic [LENGTH_BITS-1:0] count_t;

	typedef struct packed {
		logic       command;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]                result_kind;
		logic [7:0]                out_byte;
		logic [LEN_FIELD_BITS-1:0] record_length;
	} result_t;

	function automatic logic is_seq_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_DASH);
	endfunction

	// Clamp the running count to the 32-bit length field.
	function automatic logic [LEN_FIELD_BITS-1:0] clamp_len(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		if ((w >> LEN_FIELD_BITS) != 64'd0)
			return '1;
		return w[LEN_FIELD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fsp_if.sv -----
// Valid/ready channel interfaces for the parser input and result streams.
`default_nettype none
interface fsp_in_if;
	import fsp_pkg::*;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] in_byte;
	modport source(output valid, output command, output in_byte, input ready);
	modport sink(input valid, input command, input in_byte, output ready);
endinterface

interface fsp_out_if;
	import fsp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [2:0]                result_kind;
	logic [7:0]                out_byte;
	logic [LEN_FIELD_BITS-1:0] record_length;
	modport source(output valid, output result_kind, output out_byte, output record_length,
		input ready);
	modport sink(input valid, input result_kind, input out_byte, input record_length,
		output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fsp_in_stage.sv -----
// Input register stage: takes one input word per cycle unless stalled.
`default_nettype none
module fsp_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire fsp_pkg::item_t in_item,
	output logic                in_ready,
	input  wire logic           advance,
	output logic                valid_s1,
	output fsp_pkg::item_t      item_s1
);
	import fsp_pkg::*;

	// Take a new word when the register is empty or the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fsp_core.sv -----
// Parser state and per-word decode of header, sequence and end-of-input words.
`default_nettype none
module fsp_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire fsp_pkg::item_t item_s1,
	output logic                res_valid,
	output fsp_pkg::result_t    res
);
	import fsp_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] mode_d;
	count_t     count_q;
	count_t     count_d;

	always_comb begin
		mode_d    = mode_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '{result_kind: KIND_HEADER_BYTE, out_byte: 8'd0, record_length: '0};
		if (item_s1.command == CMD_END) begin
			if (mode_q == MODE_HEADER || mode_q == MODE_SEQUENCE) begin
				res_valid         = 1'b1;
				res.result_kind   = KIND_RECORD_END;
				res.record_length = clamp_len(count_q);
			end
			mode_d  = MODE_IDLE;
			count_d = '0;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (item_s1.in_byte == CH_GT) begin
						mode_d  = MODE_HEADER;
						count_d = '0;
					end
				end
				MODE_HEADER: begin
					res_valid = 1'b1;
					if (item_s1.in_byte == CH_NL) begin
						mode_d          = MODE_SEQUENCE;
						res.result_kind = KIND_HEADER_END;
					end else begin
						res.result_kind = KIND_HEADER_BYTE;
						res.out_byte    = item_s1.in_byte;
					end
				end
				MODE_SEQUENCE: begin
					case (item_s1.in_byte) inside
						CH_NL, CH_SP, CH_TAB: begin
							// skip whitespace
						end
						CH_GT: begin
							res_valid         = 1'b1;
							res.result_kind   = KIND_RECORD_END;
							res.record_length = clamp_len(count_q);
							mode_d            = MODE_HEADER;
							count_d           = '0;
						end
						default: begin
							res_valid    = 1'b1;
							res.out_byte = item_s1.in_byte;
							if (is_seq_char(item_s1.in_byte)) begin
								res.result_kind = KIND_SEQ_BYTE;
								// saturate at all ones
								if (count_q != '1)
									count_d = count_q + 1'b1;
							end else begin
								res.result_kind = KIND_ERROR;
								mode_d          = MODE_ERROR;
							end
						end
					endcase
				end
				MODE_ERROR: begin
					// drop data words until end of input
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fsp_out_stage.sv -----
// Result register: holds one result word until the output channel takes it.
`default_nettype none
module fsp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire logic             res_valid,
	input  wire fsp_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  advance,
	output logic                  out_valid_q,
	output fsp_pkg::result_t      out_res_q
);
	import fsp_pkg::*;

	// Advance when the result slot is empty or being drained
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fasta_stream_parser_top.sv -----
// A word goes from the input register through the decode to the result register.
// Throughput: one word per cycle; the decode between the input register
// and the result register sets this, and it holds while the output channel drains.
// A word with no result (skipped, ignored or dropped) leaves the output empty.
// Reset: arst_n clears both valid flags, the parser mode to idle and the count to zero.
`default_nettype none
module fasta_stream_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	fsp_in_if.sink    in_ch,
	fsp_out_if.source out_ch
);
	import fsp_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    fire;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_res_q;

	assign in_item = '{command: in_ch.command, in_byte: in_ch.in_byte};
	assign fire    = valid_s1 && advance;

	fsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_item  (in_item),
		.in_ready (in_ch.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	fsp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.res_valid   (res_valid),
		.res         (res),
		.out_ready   (out_ch.ready),
		.advance     (advance),
		.out_valid_q (out_valid_q),
		.out_res_q   (out_res_q)
	);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_kind   = out_res_q.result_kind;
	assign out_ch.out_byte      = out_res_q.out_byte;
	assign out_ch.record_length = out_res_q.record_length;

endmodule
`default_nettype wire

// ----- hw/rtl/fsp_checker.sv -----
// Port-level checks of the parser result stream, bound to the top level.
`default_nettype none
module fsp_out_assert (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [2:0]                         result_kind,
	input wire logic [7:0]                         out_byte,
	input wire logic [fsp_pkg::LEN_FIELD_BITS-1:0] record_length
);
	import fsp_pkg::*;

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(out_byte)
			&& $stable(record_length))
		else $error("result word changed while stalled");

	a_len_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_RECORD_END |-> record_length == '0)
		else $error("record length set on a non record-end word");

	a_no_byte_on_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_HEADER_END || result_kind == KIND_RECORD_END)
			|-> out_byte == 8'd0)
		else $error("byte set on a header-end or record-end word");

	a_seq_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_SEQ_BYTE |-> is_seq_char(out_byte))
		else $error("sequence byte is not a letter or gap");

endmodule

bind fasta_stream_parser_top fsp_out_assert u_fsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.result_kind   (out_ch.result_kind),
	.out_byte      (out_ch.out_byte),
	.record_length (out_ch.record_length)
);
`default_nettype wire

// ----- dv/fsp_checker.sv -----
// Checker for the FASTA stream parser: predicts each result word and compares the output.
`timescale 1ns / 1ps
module fsp_checker
	import fsp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic                      in_command,
	input  wire logic [7:0]                in_byte,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic [2:0]                out_kind,
	input  wire logic [7:0]                out_byte,
	input  wire logic [LEN_FIELD_BITS-1:0] out_length,
	output int                             mismatches,
	output int                             pending
);

	logic [1:0] parser_mode;
	count_t     seq_len;
	result_t    expected_results[$];

	initial mismatches = 0;

	assign pending = expected_results.size();

	function automatic logic [LEN_FIELD_BITS-1:0] length_field(input count_t n);
		logic [63:0] wide;
		wide = 64'(n);
		if (wide > 64'hFFFF_FFFF)
			return '1;
		return wide[LEN_FIELD_BITS-1:0];
	endfunction

	function automatic logic seq_symbol(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_DASH;
	endfunction

	// Advance the parser copy by one input word; flag whether it yields a result word.
	task automatic parse_word(input logic cmd, input logic [7:0] c,
		output bit produced, output result_t res);
		produced = 0;
		res = '0;
		if (cmd == CMD_END) begin
			if (parser_mode == MODE_HEADER || parser_mode == MODE_SEQUENCE) begin
				produced = 1;
				res.result_kind = KIND_RECORD_END;
				res.record_length = length_field(seq_len);
			end
			parser_mode = MODE_IDLE;
			seq_len = '0;
		end else begin
			case (parser_mode)
				MODE_IDLE: begin
					if (c == CH_GT) begin
						parser_mode = MODE_HEADER;
						seq_len = '0;
					end
				end
				MODE_HEADER: begin
					produced = 1;
					if (c == CH_NL) begin
						parser_mode = MODE_SEQUENCE;
						res.result_kind = KIND_HEADER_END;
					end else begin
						res.result_kind = KIND_HEADER_BYTE;
						res.out_byte = c;
					end
				end
				MODE_SEQUENCE: begin
					if (c == CH_NL || c == CH_SP || c == CH_TAB) begin
						produced = 0;
					end else if (c == CH_GT) begin
						produced = 1;
						parser_mode = MODE_HEADER;
						res.result_kind = KIND_RECORD_END;
						res.record_length = length_field(seq_len);
						seq_len = '0;
					end else if (seq_symbol(c)) begin
						produced = 1;
						if (seq_len != '1)
							seq_len = seq_len + 1'b1;
						res.result_kind = KIND_SEQ_BYTE;
						res.out_byte = c;
					end else begin
						produced = 1;
						parser_mode = MODE_ERROR;
						res.result_kind = KIND_ERROR;
						res.out_byte = c;
					end
				end
				default: produced = 0;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bit      produced;
		result_t res;
		result_t want;
		if (!arst_n) begin
			parser_mode = MODE_IDLE;
			seq_len = '0;
		end else begin
			// Compare first: a word accepted at this edge cannot have its result yet.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: kind %0d byte 0x%02h length %0d",
						out_kind, out_byte, out_length);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (out_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, actual %0d",
							want.result_kind, out_kind);
						mismatches++;
					end
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected 0x%02h, actual 0x%02h",
							want.out_byte, out_byte);
						mismatches++;
					end
					if (out_length !== want.record_length) begin
						$error("record_length: expected %0d, actual %0d",
							want.record_length, out_length);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				parse_word(in_command, in_byte, produced, res);
				if (produced)
					expected_results.push_back(res);
			end
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Top of the FASTA stream parser testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
	import fsp_pkg::*;

	localparam int RANDOM_WORDS = 700;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   idle_cycles;

	item_t stim[$];

	fsp_in_if  in_ch();
	fsp_out_if out_ch();

	fasta_stream_parser_top u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	fsp_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_command(in_ch.command),
		.in_byte   (in_ch.in_byte),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_kind  (out_ch.result_kind),
		.out_byte  (out_ch.out_byte),
		.out_length(out_ch.record_length),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic add_word(input logic cmd, input logic [7:0] b);
		item_t it;
		it.command = cmd;
		it.in_byte = b;
		stim.push_back(it);
	endtask

	function automatic logic [7:0] pick_symbol();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return 8'("A" + r);
		if (r < 52)
			return 8'("a" + r - 26);
		return CH_DASH;
	endfunction

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(2);
		return (r == 0) ? CH_SP : (r == 1) ? CH_TAB : CH_NL;
	endfunction

	task automatic build_directed();
		add_word(CMD_END, 8'hFF);        // end of input while idle
		add_word(CMD_DATA, 8'h00);       // ignored before the first marker
		add_word(CMD_DATA, 8'hFF);
		add_word(CMD_DATA, CH_GT);
		add_word(CMD_DATA, CH_GT);       // marker inside a header is a header byte
		add_word(CMD_DATA, 8'h80);
		add_word(CMD_DATA, 8'h00);
		add_word(CMD_DATA, CH_NL);
		add_word(CMD_DATA, "A");
		add_word(CMD_DATA, "z");
		add_word(CMD_DATA, CH_DASH);
		add_word(CMD_DATA, CH_SP);
		add_word(CMD_DATA, CH_TAB);
		add_word(CMD_DATA, CH_NL);
		add_word(CMD_DATA, "Z");
		add_word(CMD_DATA, CH_GT);       // close record, open header
		add_word(CMD_END, 8'h00);        // end inside a header
		add_word(CMD_DATA, CH_GT);
		add_word(CMD_DATA, CH_NL);
		add_word(CMD_DATA, "a");
		add_word(CMD_DATA, "[");         // bad byte, enter error hold
		add_word(CMD_DATA, "C");         // dropped in error hold
		add_word(CMD_DATA, CH_GT);
		add_word(CMD_END, 8'h5A);        // end in error hold
		add_word(CMD_DATA, CH_GT);
		add_word(CMD_DATA, CH_NL);
		add_word(CMD_DATA, 8'hFF);       // high byte in a sequence is an error
		add_word(CMD_END, 8'h00);
	endtask

	task automatic build_random();
		int roll;
		int n;
		int lines;
		logic [7:0] b;
		while (stim.size() < RANDOM_WORDS + 28) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				add_word(CMD_END, 8'($urandom));
			end else if (roll < 10) begin
				add_word(CMD_DATA, 8'($urandom));
			end else begin
				// Well-formed record with random content and an occasional bad byte.
				add_word(CMD_DATA, CH_GT);
				n = $urandom_range(8);
				repeat (n) begin
					b = 8'($urandom);
					if (b == CH_NL)
						b = "N";
					add_word(CMD_DATA, b);
				end
				add_word(CMD_DATA, CH_NL);
				lines = $urandom_range(1, 3);
				repeat (lines) begin
					n = $urandom_range(1, 12);
					repeat (n) begin
						roll = $urandom_range(99);
						if (roll < 3)
							add_word(CMD_DATA, 8'($urandom));
						else if (roll < 12)
							add_word(CMD_DATA, pick_blank());
						else
							add_word(CMD_DATA, pick_symbol());
					end
					add_word(CMD_DATA, CH_NL);
				end
				if ($urandom_range(9) == 0)
					add_word(CMD_END, 8'($urandom));
			end
		end
	endtask

	// Sender: hold a word until taken, else idle at random except over words 200 to 349.
	initial begin
		int idx;
		in_ch.valid   <= 1'b0;
		in_ch.command <= CMD_DATA;
		in_ch.in_byte <= 8'h00;
		build_directed();
		build_random();
		while (!arst_n)
			@(posedge clk);
		idx = 0;
		while (idx < stim.size()) begin
			@(posedge clk);
			if (in_ch.valid && in_ch.ready)
				idx++;
			if (in_ch.valid && !in_ch.ready) begin
				// hold the offered word
			end else if (idx < stim.size() &&
				((idx >= 200 && idx < 350) || $urandom_range(99) >= 30)) begin
				in_ch.valid   <= 1'b1;
				in_ch.command <= stim[idx].command;
				in_ch.in_byte <= stim[idx].in_byte;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: random stalls, one long hold-off to back up the input, one stall-free stretch.
	initial begin
		int cyc;
		int hold_left;
		out_ch.ready <= 1'b0;
		cyc = 0;
		hold_left = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (cyc == 400) begin
				hold_left = 150;
				out_ch.ready <= 1'b0;
			end else if (cyc >= 700 && cyc < 900) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 30);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
